/* sv/lruc_pkg.sv */
// Shared constants and types of the LRU cache tag store.
package lruc_pkg;

  // Stamp and statistics counters wrap at 32 bits
  localparam int STAMP_W = 32;
  localparam int COUNT_W = 32;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd2;

  // Request opcodes
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_STORE  = 2'd1;
  localparam logic [1:0] OP_MODIFY = 2'd2;

  // Geometry registers as held by the core
  typedef struct packed {
    logic [2:0] set_bits;
    logic [5:0] block_bits;
    logic [3:0] ways_in_use;
  } cfg_t;

endpackage

/* sv/lruc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module lruc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds its data between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/lruc_decode.sv */
// Address split into set index and tag, and the mask of ways in use.
module lruc_decode #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS = 8,
  parameter int TAG_WIDTH = 32,
  localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1
) (
  input  lruc_pkg::cfg_t       cfg,
  input  logic [63:0]          address,
  output logic [SET_W-1:0]     set_index,
  output logic [TAG_WIDTH-1:0] tag,
  output logic [MAX_WAYS-1:0]  active
);

  logic [3:0]       sb;
  logic [6:0]       total;
  logic [63:0]      tag_sh;
  logic [63:0]      set_sh;
  logic [SET_W-1:0] set_mask;
  logic [4:0]       ways;

  // Clamp set bits to the size of the store
  always_comb begin
    if ({1'b0, cfg.set_bits} > 4'(MAX_SET_BITS)) begin
      sb = 4'(MAX_SET_BITS);
    end else begin
      sb = {1'b0, cfg.set_bits};
    end
  end

  // Tag: everything above set and offset, zero once the shift leaves the word
  assign total  = 7'(sb) + 7'(cfg.block_bits);
  assign tag_sh = address >> total[5:0];
  assign tag    = total[6] ? '0 : tag_sh[TAG_WIDTH-1:0];

  // Set index: the sb bits above the byte offset
  assign set_sh    = address >> cfg.block_bits;
  assign set_mask  = ~({SET_W{1'b1}} << sb);
  assign set_index = set_sh[SET_W-1:0] & set_mask;

  // Ways in use: zero acts as one, clamp to the number built
  always_comb begin
    ways = (cfg.ways_in_use == 4'd0) ? 5'd1 : {1'b0, cfg.ways_in_use};
    if (ways > 5'(MAX_WAYS)) begin
      ways = 5'(MAX_WAYS);
    end
    for (int i = 0; i < MAX_WAYS; i++) begin
      active[i] = (5'(i) < ways);
    end
  end

endmodule

/* sv/lruc_victim.sv */
// Oldest-way search over one set: a compare tree, lowest way wins a tie.
module lruc_victim #(
  parameter int MAX_WAYS = 8,
  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
  input  logic [MAX_WAYS-1:0][lruc_pkg::STAMP_W-1:0] age,
  output logic [WAY_W-1:0]                           victim
);

  localparam int LV = $clog2(MAX_WAYS);
  localparam int NP = 1 << LV;

  logic [lruc_pkg::STAMP_W-1:0] a  [NP];
  logic [WAY_W-1:0]             wi [NP];

  // Reduce pairwise; the left side keeps ties so lower indices win
  always_comb begin
    for (int i = 0; i < NP; i++) begin
      a[i]  = (i < MAX_WAYS) ? age[i] : '0;
      wi[i] = WAY_W'(i);
    end
    for (int lv = 0; lv < LV; lv++) begin
      for (int i = 0; i < (NP >> (lv + 1)); i++) begin
        if (a[2*i+1] > a[2*i]) begin
          a[i]  = a[2*i+1];
          wi[i] = wi[2*i+1];
        end else begin
          a[i]  = a[2*i];
          wi[i] = wi[2*i];
        end
      end
    end
    victim = wi[0];
  end

endmodule

/* sv/lru_set_associative_cache_tags_core.sv */
// Top level of the LRU set-associative cache tag store.
//
// Requests enter on start with address and opcode, taken when start is high
// and busy is low. Load and store make one access, modify makes two to the
// same address; opcode 3 is taken and makes no access and no result.
// Each access reads one set row (valid bits, tags, stamps of all ways) from
// a single RAM, compares all ways in parallel, picks the oldest way through a
// compare tree, and writes the row back. An access runs through the read
// issue, the lookup and the update with write-back. The result appears on
// the outputs with done high for one cycle, registered from the update; a
// new request is taken only back in idle, so a modify holds off the next one
// until its second access (which re-reads the row written by the first) ends.
// The receiver cannot stall: every result is taken in the cycle it shows.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready; write it only while no request is in flight.
// After reset the core sweeps the RAM clearing all 2**MAX_SET_BITS set rows,
// one row per cycle, with busy high; configuration writes are still taken
// during the sweep. Counters and the access clock reset to zero.
module lru_set_associative_cache_tags_core #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS = 8,
  parameter int TAG_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [63:0]                        address,
  input  logic [1:0]                         opcode,
  output logic                               busy,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lruc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lruc_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                               done,
  output logic                               was_hit,
  output logic                               was_evicted,
  output logic [lruc_pkg::COUNT_W-1:0]       hit_total,
  output logic [lruc_pkg::COUNT_W-1:0]       miss_total,
  output logic [lruc_pkg::COUNT_W-1:0]       evict_total,
  output logic                               is_last
);

  localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int SW       = lruc_pkg::STAMP_W;
  localparam int ROW_W    = MAX_WAYS * (1 + TAG_WIDTH + SW);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_LOOKUP = 5'b00100,
    S_UPDATE = 5'b01000,
    S_REREAD = 5'b10000
  } state_t;

  state_t state, state_next;

  lruc_pkg::cfg_t cfg;

  logic [SET_W-1:0]     clr_idx;
  logic [SET_W-1:0]     dec_set;
  logic [TAG_WIDTH-1:0] dec_tag;
  logic [MAX_WAYS-1:0]  active;
  logic [SET_W-1:0]     set_q;
  logic [TAG_WIDTH-1:0] tag_q;
  logic                 pend;
  logic                 accept;
  logic                 op_ok;

  logic [SW-1:0]                      access_clock;
  logic [lruc_pkg::COUNT_W-1:0]       hits, misses, evicts;
  logic [lruc_pkg::COUNT_W-1:0]       hits_next, misses_next, evicts_next;

  // RAM ports
  logic                 ram_we, ram_re;
  logic [SET_W-1:0]     ram_waddr, ram_raddr;
  logic [ROW_W-1:0]     ram_wdata, ram_rdata;

  // Row as read
  logic [MAX_WAYS-1:0]                 rd_valid;
  logic [MAX_WAYS-1:0][TAG_WIDTH-1:0]  rd_tags;
  logic [MAX_WAYS-1:0][SW-1:0]         rd_stamps;

  // Lookup results
  logic [MAX_WAYS-1:0]         hit_vec, free_vec;
  logic [WAY_W-1:0]            hit_way, free_way;
  logic [MAX_WAYS-1:0][SW-1:0] age;

  // Registered row and lookup results
  logic [MAX_WAYS-1:0]                 valid_q;
  logic [MAX_WAYS-1:0][TAG_WIDTH-1:0]  tags_q;
  logic [MAX_WAYS-1:0][SW-1:0]         stamps_q;
  logic                                hit_q, free_q;
  logic [WAY_W-1:0]                    hit_way_q, free_way_q;
  logic [MAX_WAYS-1:0][SW-1:0]         age_q;

  // Update
  logic [WAY_W-1:0]                    victim, pick;
  logic                                evict;
  logic [MAX_WAYS-1:0]                 valid_n;
  logic [MAX_WAYS-1:0][TAG_WIDTH-1:0]  tags_n;
  logic [MAX_WAYS-1:0][SW-1:0]         stamps_n;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign op_ok     = (opcode == lruc_pkg::OP_LOAD) || (opcode == lruc_pkg::OP_STORE) ||
                     (opcode == lruc_pkg::OP_MODIFY);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.set_bits    <= '0;
      cfg.block_bits  <= '0;
      cfg.ways_in_use <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lruc_pkg::CFG_SET_BITS:   cfg.set_bits    <= cfg_data[2:0];
        lruc_pkg::CFG_BLOCK_BITS: cfg.block_bits  <= cfg_data[5:0];
        lruc_pkg::CFG_WAYS:       cfg.ways_in_use <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  lruc_decode #(
    .MAX_SET_BITS(MAX_SET_BITS),
    .MAX_WAYS(MAX_WAYS),
    .TAG_WIDTH(TAG_WIDTH)
  ) u_decode (
    .cfg(cfg),
    .address(address),
    .set_index(dec_set),
    .tag(dec_tag),
    .active(active)
  );

  lruc_ram #(
    .WIDTH(ROW_W),
    .DEPTH(NUM_SETS)
  ) u_ram (
    .clk(clk),
    .we(ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re(ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Read on a taken request, or again for the second access of a modify
  assign ram_re    = (accept && op_ok) || (state == S_REREAD);
  assign ram_raddr = (state == S_REREAD) ? set_q : dec_set;

  // Write the cleared row during the sweep, the updated row otherwise
  assign ram_we    = (state == S_CLEAR) || (state == S_UPDATE);
  assign ram_waddr = (state == S_CLEAR) ? clr_idx : set_q;
  assign ram_wdata = (state == S_CLEAR) ? '0 : {stamps_n, tags_n, valid_n};

  // Unpack the row
  always_comb begin
    rd_valid = ram_rdata[MAX_WAYS-1:0];
    for (int w = 0; w < MAX_WAYS; w++) begin
      rd_tags[w]   = ram_rdata[MAX_WAYS + w*TAG_WIDTH +: TAG_WIDTH];
      rd_stamps[w] = ram_rdata[MAX_WAYS + MAX_WAYS*TAG_WIDTH + w*SW +: SW];
    end
  end

  // Compare all ways, find first hit and first free way, form ages
  always_comb begin
    hit_way  = '0;
    free_way = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      hit_vec[w]  = active[w] && rd_valid[w] && (rd_tags[w] == tag_q);
      free_vec[w] = active[w] && !rd_valid[w];
      age[w]      = active[w] ? (access_clock - rd_stamps[w]) : '0;
    end
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = WAY_W'(w);
      end
      if (free_vec[w]) begin
        free_way = WAY_W'(w);
      end
    end
  end

  // Hold the row and the lookup results for the update cycle
  always_ff @(posedge clk) begin
    if (state == S_LOOKUP) begin
      valid_q    <= rd_valid;
      tags_q     <= rd_tags;
      stamps_q   <= rd_stamps;
      hit_q      <= |hit_vec;
      free_q     <= |free_vec;
      hit_way_q  <= hit_way;
      free_way_q <= free_way;
      age_q      <= age;
    end
  end

  lruc_victim #(
    .MAX_WAYS(MAX_WAYS)
  ) u_victim (
    .age(age_q),
    .victim(victim)
  );

  // Choose the way to refresh or fill, and build the new row
  always_comb begin
    evict = !hit_q && !free_q;
    if (hit_q) begin
      pick = hit_way_q;
    end else if (free_q) begin
      pick = free_way_q;
    end else begin
      pick = victim;
    end
    valid_n  = valid_q;
    tags_n   = tags_q;
    stamps_n = stamps_q;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (WAY_W'(w) == pick) begin
        valid_n[w]  = 1'b1;
        tags_n[w]   = tag_q;
        stamps_n[w] = access_clock;
      end
    end
  end

  assign hits_next   = hits + lruc_pkg::COUNT_W'(hit_q);
  assign misses_next = misses + lruc_pkg::COUNT_W'(!hit_q);
  assign evicts_next = evicts + lruc_pkg::COUNT_W'(evict);

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_idx == SET_W'(NUM_SETS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept && op_ok) begin
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: state_next = S_UPDATE;
      S_UPDATE: state_next = pend ? S_REREAD : S_IDLE;
      S_REREAD: state_next = S_LOOKUP;
      default:  state_next = S_IDLE;
    endcase
  end

  // Control state, counters and the clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_idx      <= '0;
      pend         <= 1'b0;
      done         <= 1'b0;
      access_clock <= '0;
      hits         <= '0;
      misses       <= '0;
      evicts       <= '0;
    end else begin
      state <= state_next;
      done  <= (state == S_UPDATE);
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (accept && op_ok) begin
        pend <= (opcode == lruc_pkg::OP_MODIFY);
      end else if (state == S_UPDATE) begin
        pend <= 1'b0;
      end
      if (state == S_UPDATE) begin
        access_clock <= access_clock + 1'b1;
        hits         <= hits_next;
        misses       <= misses_next;
        evicts       <= evicts_next;
      end
    end
  end

  // Latch the request's set and tag
  always_ff @(posedge clk) begin
    if (accept && op_ok) begin
      set_q <= dec_set;
      tag_q <= dec_tag;
    end
  end

  // Result registers, shown for one cycle with done
  always_ff @(posedge clk) begin
    if (state == S_UPDATE) begin
      was_hit     <= hit_q;
      was_evicted <= evict;
      hit_total   <= hits_next;
      miss_total  <= misses_next;
      evict_total <= evicts_next;
      is_last     <= !pend;
    end
  end

  // Checks
  a_done_after_update: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_UPDATE))
    else $error("result strobe without an update cycle");

  a_hit_not_evict: assert property (@(posedge clk) disable iff (rst)
    done |-> !(was_hit && was_evicted))
    else $error("hit reported together with an eviction");

  a_clock_matches_counts: assert property (@(posedge clk) disable iff (rst)
    access_clock == (hits + misses))
    else $error("access clock out of step with hit and miss counts");

  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    (accept && op_ok) |=> (state == S_LOOKUP))
    else $error("taken request did not start a lookup");

  a_write_owner: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> ((state == S_CLEAR) || (state == S_UPDATE)))
    else $error("tag RAM written outside sweep or update");

endmodule
